### src/two_level_priority_queue_core_macros.svh
// Assertion macros shared by the two-level priority queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TWO_LEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH
`define TWO_LEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTH
// Check that is disabled while reset is asserted.
`define TLPQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tlpq assertion failed");
// Check that also holds during reset.
`define TLPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("tlpq assertion failed");
`else
`define TLPQ_ASSERT(label, clk, rst_n, prop)
`define TLPQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### src/tlpq_pkg.sv
// Package for the two-level priority queue: sizes, codes, control types.
// No dependencies; used by every module of the block except tlpq_ram.
`default_nettype none
package tlpq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int DATA_W      = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // priority levels
  localparam logic LEVEL_HIGH = 1'b0;
  localparam logic LEVEL_LOW  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the accepted transaction
    logic exec;     // update queues and start the RAM read
    logic capture;  // take the RAM read data into the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;  // pending delete will pop a value
  } dp_stat_t;

endpackage
`default_nettype wire

### src/tlpq_in_if.sv
// Input channel of the two-level priority queue: valid/ready plus operation.
// Depends on tlpq_pkg.
`default_nettype none
interface tlpq_in_if
  import tlpq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [DATA_W-1:0] data_in;
  logic                     level;

  modport source (output valid, output func, output data_in, output level, input ready);
  modport sink   (input valid, input func, input data_in, input level, output ready);
endinterface
`default_nettype wire

### src/tlpq_out_if.sv
// Result channel of the two-level priority queue: valid/ready plus result.
// Depends on tlpq_pkg.
`default_nettype none
interface tlpq_out_if
  import tlpq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data_out;
  logic                     served_level;

  modport source (output valid, output status, output data_out, output served_level,
                  input ready);
  modport sink   (input valid, input status, input data_out, input served_level,
                  output ready);
endinterface
`default_nettype wire

### src/tlpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/tlpq_dp.sv
// Datapath: operation register, two circular FIFOs (pointers, counts, RAMs)
// and the result register. Depends on tlpq_pkg, tlpq_ram and the macro header.
`include "two_level_priority_queue_core_macros.svh"
`default_nettype none
module tlpq_dp
  import tlpq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  output      dp_stat_t                 stat,
  input  wire logic                     in_func,
  input  wire logic signed [DATA_W-1:0] in_data,
  input  wire logic                     in_level,
  output      status_t                  res_status,
  output      logic signed [DATA_W-1:0] res_data,
  output      logic                     res_served
);

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // captured transaction
  logic              func_r;
  logic [DATA_W-1:0] data_r;
  logic              level_r;

  // queue pointers and fill counts
  logic [PTR_W-1:0] hhead_r, hhead_nxt, htail_r, htail_nxt;
  logic [PTR_W-1:0] lhead_r, lhead_nxt, ltail_r, ltail_nxt;
  logic [CNT_W-1:0] hcnt_r, hcnt_nxt, lcnt_r, lcnt_nxt;

  // result
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic              served_r, served_nxt;

  logic              h_we, l_we, h_re, l_re;
  logic [DATA_W-1:0] h_rdata, l_rdata;
  logic              h_full, l_full, h_empty, l_empty;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign h_full  = (hcnt_r == FULL_CNT);
  assign l_full  = (lcnt_r == FULL_CNT);
  assign h_empty = (hcnt_r == '0);
  assign l_empty = (lcnt_r == '0);

  assign stat.need_read = (func_r == FUNC_DELETE) && !(h_empty && l_empty);

  // transaction register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      data_r  <= in_data;
      level_r <= in_level;
    end
  end

  // queue update for the pending operation
  always_comb begin
    hhead_nxt  = hhead_r;
    htail_nxt  = htail_r;
    hcnt_nxt   = hcnt_r;
    lhead_nxt  = lhead_r;
    ltail_nxt  = ltail_r;
    lcnt_nxt   = lcnt_r;
    status_nxt = status_r;
    served_nxt = served_r;
    h_we = 1'b0;
    l_we = 1'b0;
    h_re = 1'b0;
    l_re = 1'b0;
    if (cmd.exec) begin
      status_nxt = ST_OK;
      served_nxt = LEVEL_HIGH;
      if (func_r == FUNC_INSERT) begin
        if (level_r == LEVEL_HIGH) begin
          if (h_full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            h_we      = 1'b1;
            htail_nxt = next_slot(htail_r);
            hcnt_nxt  = hcnt_r + 1'b1;
          end
        end else begin
          if (l_full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            l_we      = 1'b1;
            ltail_nxt = next_slot(ltail_r);
            lcnt_nxt  = lcnt_r + 1'b1;
          end
        end
      end else if (!h_empty) begin
        h_re      = 1'b1;
        hhead_nxt = next_slot(hhead_r);
        hcnt_nxt  = hcnt_r - 1'b1;
      end else if (!l_empty) begin
        l_re       = 1'b1;
        lhead_nxt  = next_slot(lhead_r);
        lcnt_nxt   = lcnt_r - 1'b1;
        served_nxt = LEVEL_LOW;
      end else begin
        status_nxt = ST_UNDERFLOW;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hhead_r <= '0;
      htail_r <= '0;
      hcnt_r  <= '0;
      lhead_r <= '0;
      ltail_r <= '0;
      lcnt_r  <= '0;
    end else begin
      hhead_r <= hhead_nxt;
      htail_r <= htail_nxt;
      hcnt_r  <= hcnt_nxt;
      lhead_r <= lhead_nxt;
      ltail_r <= ltail_nxt;
      lcnt_r  <= lcnt_nxt;
    end
  end

  // result registers; data is zero unless a popped value is captured
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    served_r <= served_nxt;
    if (cmd.exec) begin
      rdata_r <= '0;
    end else if (cmd.capture) begin
      rdata_r <= (served_r == LEVEL_LOW) ? l_rdata : h_rdata;
    end
  end

  assign res_status = status_r;
  assign res_data   = rdata_r;
  assign res_served = served_r;

  // value storage
  tlpq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_high_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (htail_r),
    .wdata (data_r),
    .re    (h_re),
    .raddr (hhead_r),
    .rdata (h_rdata)
  );

  tlpq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_low_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (ltail_r),
    .wdata (data_r),
    .re    (l_re),
    .raddr (lhead_r),
    .rdata (l_rdata)
  );

  // checks
  `TLPQ_ASSERT(a_cnt_bound, clk, rst_n, (hcnt_r <= FULL_CNT) && (lcnt_r <= FULL_CNT))
  `TLPQ_ASSERT(a_pop_nonempty, clk, rst_n, (h_re |-> !h_empty) and (l_re |-> !l_empty))
  `TLPQ_ASSERT(a_low_only_if_high_empty, clk, rst_n, l_re |-> h_empty)
  `TLPQ_ASSERT(a_idle_stable, clk, rst_n, !cmd.exec |=> $stable(hcnt_r) && $stable(lcnt_r))

endmodule
`default_nettype wire

### src/tlpq_ctrl.sv
// Controller: one-hot sequencer for accept, execute, read and result phases.
// Depends on tlpq_pkg.
`default_nettype none
module tlpq_ctrl
  import tlpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  output      logic     out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output      cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.load    = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.capture = (state_r == S_READ);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = stat.need_read ? S_READ : S_OUT;
      S_READ: state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### src/two_level_priority_queue_core.sv
// Top level of the two-level priority queue: controller plus datapath.
// Depends on tlpq_pkg, tlpq_in_if, tlpq_out_if, tlpq_ctrl, tlpq_dp.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   func, data_in, level
//   out_ch   out  valid/ready   status, data_out, served_level
//
// Insert or underflowing delete: steps accept, execute and result; the result
// is valid after the execute state that follows the input transaction.
// Popping delete: adds a read step for the registered FIFO RAM read.
// One operation in flight; the next is taken once the result transaction
// completes. out_ch stalls hold the result and block in_ch.
// Synchronous reset empties both FIFOs; no clearing pass is needed.
`default_nettype none
module two_level_priority_queue_core
  import tlpq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  tlpq_in_if.sink   in_ch,
  tlpq_out_if.source out_ch
);

  cmd_t     cmd;
  dp_stat_t stat;
  status_t  res_status;

  tlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlpq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_ch.func),
    .in_data    (in_ch.data_in),
    .in_level   (in_ch.level),
    .res_status (res_status),
    .res_data   (out_ch.data_out),
    .res_served (out_ch.served_level)
  );

  assign out_ch.status = res_status;

endmodule
`default_nettype wire

### test/tb_two_level_priority_queue_core.sv
// Testbench for two_level_priority_queue_core: directed and random insert/delete traffic
// with idle and stall bursts, checked against an in-bench model of the two FIFOs.
// Depends on tlpq_pkg, tlpq_in_if, tlpq_out_if and the core RTL.
module tb_two_level_priority_queue_core;
  import tlpq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     level;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  tlpq_in_if  in_ch();
  tlpq_out_if out_ch();

  two_level_priority_queue_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model of both FIFOs, index 0 = high level, 1 = low level
  logic [DATA_W-1:0] fifo_mem [2][QUEUE_DEPTH];
  logic [PTR_W-1:0]  fifo_rd  [2];
  logic [PTR_W-1:0]  fifo_wr  [2];
  logic [CNT_W-1:0]  fifo_cnt [2];

  queue_result_t pending_results[$];
  queue_result_t oldest_result;
  int            err_count = 0;
  int            cycle_count = 0;
  bit            send_idle_on = 1'b0;
  bit            sink_stall_on = 1'b0;
  int            stall_left = 0;

  function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one operation to the model and return the result it must produce.
  function automatic queue_result_t queue_model_apply(logic func, logic [DATA_W-1:0] value,
                                                      logic lvl);
    queue_result_t r;
    int            src;
    r.status = ST_OK;
    r.data   = '0;
    r.level  = LEVEL_HIGH;
    if (func == FUNC_INSERT) begin
      src = (lvl == LEVEL_HIGH) ? 0 : 1;
      if (fifo_cnt[src] == CNT_W'(QUEUE_DEPTH)) begin
        r.status = ST_OVERFLOW;
      end else begin
        fifo_mem[src][fifo_wr[src]] = value;
        fifo_wr[src]  = wrap_inc(fifo_wr[src]);
        fifo_cnt[src] = fifo_cnt[src] + 1'b1;
      end
    end else if (fifo_cnt[0] != 0 || fifo_cnt[1] != 0) begin
      // high level always wins when it holds anything
      src = (fifo_cnt[0] != 0) ? 0 : 1;
      r.data        = fifo_mem[src][fifo_rd[src]];
      r.level       = (src == 0) ? LEVEL_HIGH : LEVEL_LOW;
      fifo_rd[src]  = wrap_inc(fifo_rd[src]);
      fifo_cnt[src] = fifo_cnt[src] - 1'b1;
    end else begin
      r.status = ST_UNDERFLOW;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // Send one operation; returns at the edge where the transaction is taken.
  task automatic send_op(logic func, logic [DATA_W-1:0] value, logic lvl);
    int gap;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= func;
    in_ch.data_in <= value;
    in_ch.level   <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // predict on every accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_results.push_back(queue_model_apply(in_ch.func, in_ch.data_in, in_ch.level));
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, data", out_ch.data_out, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_ch.status != oldest_result.status)
          report_mismatch("status", DATA_W'(out_ch.status), DATA_W'(oldest_result.status));
        if (out_ch.data_out != oldest_result.data)
          report_mismatch("data_out", out_ch.data_out, oldest_result.data);
        if (out_ch.served_level != oldest_result.level)
          report_mismatch("served_level", DATA_W'(out_ch.served_level),
                          DATA_W'(oldest_result.level));
      end
    end
  end

  // result side backpressure in random bursts, started while sink_stall_on is set
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_two_level_priority_queue_core: done, errors");
      $finish;
    end
  end

  // Priority order and value extremes, starting from an empty queue.
  task automatic test_priority_and_extremes();
    send_op(FUNC_DELETE, 32'h1234_5678, LEVEL_LOW);
    send_op(FUNC_INSERT, 32'h7FFF_FFFF, LEVEL_LOW);
    send_op(FUNC_INSERT, 32'h8000_0000, LEVEL_HIGH);
    send_op(FUNC_DELETE, 32'hFFFF_FFFF, LEVEL_HIGH);
    send_op(FUNC_DELETE, 32'h0000_0000, LEVEL_LOW);
  endtask

  // Fill the high FIFO, overflow it, then drain through to the low level and empty.
  task automatic test_fill_and_overflow();
    logic [DATA_W-1:0] fill_vals [QUEUE_DEPTH];
    fill_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE};
    foreach (fill_vals[i]) send_op(FUNC_INSERT, fill_vals[i], LEVEL_HIGH);
    send_op(FUNC_INSERT, 32'hDEAD_BEEF, LEVEL_HIGH);
    send_op(FUNC_INSERT, 32'hFFFF_FFFF, LEVEL_LOW);
    repeat (QUEUE_DEPTH + 1) send_op(FUNC_DELETE, $urandom, 1'($urandom));
    send_op(FUNC_DELETE, 32'h0, LEVEL_HIGH);
  endtask

  // Random traffic in segments with varying insert bias so both FIFOs hit full and empty.
  task automatic test_random_traffic(int n_items);
    int                bias;
    logic              func;
    logic [DATA_W-1:0] value;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 4))
          0: bias = 10;
          1: bias = 30;
          2: bias = 50;
          3: bias = 70;
          default: bias = 90;
        endcase
        send_idle_on  = ($urandom_range(0, 3) != 0);
        sink_stall_on = ($urandom_range(0, 3) != 0);
      end
      func = ($urandom_range(0, 99) < bias) ? FUNC_INSERT : FUNC_DELETE;
      case ($urandom_range(0, 15))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'hFFFF_FFFF;
        3: value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      send_op(func, value, 1'($urandom));
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_back_to_back(int n_items);
    send_idle_on  = 1'b0;
    sink_stall_on = 1'b0;
    for (int i = 0; i < n_items; i++)
      send_op(1'($urandom), $urandom, 1'($urandom));
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_INSERT;
    in_ch.data_in = '0;
    in_ch.level   = LEVEL_HIGH;
    out_ch.ready  = 1'b0;
    for (int l = 0; l < 2; l++) begin
      fifo_rd[l]  = '0;
      fifo_wr[l]  = '0;
      fifo_cnt[l] = '0;
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_priority_and_extremes();
    test_fill_and_overflow();
    test_random_traffic(1300);
    test_back_to_back(200);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (err_count == 0) begin
      $display("tb_two_level_priority_queue_core: done, clean");
    end else begin
      $display("tb_two_level_priority_queue_core: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/tlpq_pkg.sv
src/tlpq_in_if.sv
src/tlpq_out_if.sv
src/tlpq_ram.sv
src/tlpq_dp.sv
src/tlpq_ctrl.sv
src/two_level_priority_queue_core.sv
test/tb_two_level_priority_queue_core.sv
